### hdl/cfft_pkg.sv
// shared types, codes and helpers for the complex radix-2 fft block
// no dependencies
package cfft_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int WORD_BITS      = 32;
   localparam int BIN_INDEX_BITS = 10;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 4;
   localparam int POINTS_BITS    = 4;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_INVERSE = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_POINTS  = 1'b1;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_READ = 1'b1;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_NO_FRAME = 1'b1;

   localparam logic [POINTS_BITS-1:0] POINTS_RESET = 4'd10;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] re;
      logic signed [WORD_BITS-1:0] im;
   } cplx_type;

   typedef struct packed {
      logic cap_a;
      logic pre;
      logic mul;
      logic rnd;
      logic inverse;
   } bfly_ctrl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RSP,
      ST_BF_RD_T,
      ST_BF_RD_U,
      ST_BF_PRE,
      ST_BF_MUL,
      ST_BF_RND,
      ST_BF_WR_T,
      ST_BF_WR_U,
      ST_BR_RD_I,
      ST_BR_RD_R,
      ST_BR_WR_I,
      ST_BR_WR_R,
      ST_SC_RD,
      ST_SC_WR,
      ST_FINISH
   } fsm_type;

   function automatic logic signed [WORD_BITS-1:0] sat32(input logic signed [WORD_BITS:0] v);
      if (v[WORD_BITS] == v[WORD_BITS-1]) begin
         return v[WORD_BITS-1:0];
      end
      return v[WORD_BITS] ? {1'b1, {(WORD_BITS-1){1'b0}}} : {1'b0, {(WORD_BITS-1){1'b1}}};
   endfunction

   function automatic logic signed [WORD_BITS-1:0] add_sat(input logic signed [WORD_BITS-1:0] a,
                                                          input logic signed [WORD_BITS-1:0] b);
      return sat32({a[WORD_BITS-1], a} + {b[WORD_BITS-1], b});
   endfunction

   function automatic logic signed [WORD_BITS-1:0] sub_sat(input logic signed [WORD_BITS-1:0] a,
                                                          input logic signed [WORD_BITS-1:0] b);
      return sat32({a[WORD_BITS-1], a} - {b[WORD_BITS-1], b});
   endfunction

endpackage

### hdl/cfft_req_if.sv
// request channel: valid, ready and the load or read item
// depends on cfft_pkg
interface cfft_req_if import cfft_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic                          action;
   logic signed [SAMPLE_BITS-1:0] sample_re;
   logic signed [SAMPLE_BITS-1:0] sample_im;

   modport source (output valid, action, sample_re, sample_im, input ready);
   modport sink (input valid, action, sample_re, sample_im, output ready);
endinterface

### hdl/cfft_rsp_if.sv
// response channel: valid, ready and the result bin
// depends on cfft_pkg
interface cfft_rsp_if import cfft_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] bin_re;
   logic signed [WORD_BITS-1:0] bin_im;
   logic [BIN_INDEX_BITS-1:0]   bin_index;
   logic                        last_bin;
   logic                        status;

   modport source (output valid, bin_re, bin_im, bin_index, last_bin, status, input ready);
   modport sink (input valid, bin_re, bin_im, bin_index, last_bin, status, output ready);
endinterface

### hdl/complex_radix2_fft_top.sv
// complex radix-2 fft top level: channels, configuration, sequencer
// depends on cfft_pkg, cfft_req_if, cfft_rsp_if, cfft_work_ram, cfft_twiddle_rom, cfft_butterfly
//
// usage
//   req carries items: action load writes sample_re/sample_im at the next frame position,
//   action read returns the next bin of the finished frame on rsp.
//   csr_we/csr_index/csr_wdata write inverse_mode (index 0) and points_log2 (index 1).
//   loading N = 2^points_log2 samples (clamped to 2..MAX_POINTS) starts the transform in place.
// operation
//   a load is written on acceptance; a read's bin passes the memory read and output registers.
//   the transform runs on a single-port-read, single-port-write memory:
//   each butterfly steps through read t, read u, pre, mul, rnd, write t, write u;
//   log2(N)*N/2 butterflies per frame; bit reversal reads each index and, per swap,
//   reads the partner and writes both back; the inverse adds a read and a write per point
//   for the 1/N scaling. req is accepted again once the transform has finished.
// reset
//   synchronous; clears the load and read counters, frame flag, output valid and registers to
//   forward mode with points_log2 = 10. memory contents are not cleared.
// stall
//   one output register; req is held off while a bin waits and rsp.ready is low.
module complex_radix2_fft_top import cfft_pkg::*; #(
   parameter int MAX_POINTS   = 1024,
   parameter int TWIDDLE_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   cfft_req_if.sink                  req,
   cfft_rsp_if.source                rsp,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int AW  = $clog2(MAX_POINTS);
   localparam int LGW = $clog2(AW + 1);
   localparam int CW  = AW + 1;
   localparam int RW  = (AW > 1) ? AW - 1 : 1;

   fsm_type state_ff, state_in;

   logic                   inverse_ff;
   logic [POINTS_BITS-1:0] points_ff;
   logic [CW-1:0]          load_count_ff, read_count_ff;
   logic                   frame_ready_ff;
   logic [AW-1:0]          k_ff, i_ff;
   logic [LGW-1:0]         hl_ff;

   logic                      pend_status_ff, pend_last_ff;
   logic [BIN_INDEX_BITS-1:0] pend_index_ff;
   logic                      rsp_valid_ff;
   cplx_type                  rsp_data_ff;
   logic [BIN_INDEX_BITS-1:0] rsp_index_ff;
   logic                      rsp_last_ff, rsp_status_ff;

   logic [LGW-1:0] lg;
   logic [4:0]     pl;
   logic [CW-1:0]  n_full, n_last, load_next;
   logic [AW-1:0]  half_last, lowmask, bf_t, bf_u, rev, br_r;
   logic [RW-1:0]  tw_addr;
   logic           trigger, k_last, stage_last, i_last, do_swap;
   logic           req_accept, req_ready;

   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   cplx_type      ram_wdata, ram_rdata, load_word, scaled;
   logic          rom_en;
   logic signed [TWIDDLE_BITS:0] w_cos, w_sin;
   bfly_ctrl_type bctl;
   cplx_type      res_t, res_u, hold;

   logic signed [WORD_BITS:0] sc_re, sc_im, sc_half;

   cfft_work_ram #(.ADDR_BITS(AW)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   cfft_twiddle_rom #(.MAX_POINTS(MAX_POINTS), .TWIDDLE_BITS(TWIDDLE_BITS)) u_rom (
      .clock   (clock),
      .rd_en   (rom_en),
      .rd_addr (tw_addr),
      .cos_out (w_cos),
      .sin_out (w_sin)
   );

   cfft_butterfly #(.TWIDDLE_BITS(TWIDDLE_BITS)) u_bfly (
      .clock   (clock),
      .ctrl    (bctl),
      .rd_data (ram_rdata),
      .w_cos   (w_cos),
      .w_sin   (w_sin),
      .res_t   (res_t),
      .res_u   (res_u),
      .hold    (hold)
   );

   // effective length and address generation
   always_comb begin
      pl = {1'b0, points_ff};
      if (pl == 5'd0) begin
         lg = LGW'(1);
      end else if (pl > 5'(AW)) begin
         lg = LGW'(AW);
      end else begin
         lg = LGW'(pl);
      end
      n_full    = CW'(1) << lg;
      n_last    = n_full - CW'(1);
      half_last = AW'(n_full >> 1) - AW'(1);
      load_next = load_count_ff + CW'(1);
      trigger   = load_next >= n_full;
      lowmask   = (AW'(1) << hl_ff) - AW'(1);
      bf_t      = AW'((k_ff & ~lowmask) << 1) | (k_ff & lowmask);
      bf_u      = bf_t | (AW'(1) << hl_ff);
      tw_addr   = RW'((k_ff & lowmask) << (LGW'(AW - 1) - hl_ff));
      k_last    = k_ff == half_last;
      stage_last = inverse_ff ? (hl_ff == lg - LGW'(1)) : (hl_ff == '0);
      i_last    = i_ff == AW'(n_last);
      for (int b = 0; b < AW; b++) begin
         rev[b] = i_ff[AW-1-b];
      end
      br_r    = rev >> (LGW'(AW) - lg);
      do_swap = br_r > i_ff;
   end

   // inverse scaling with rounding, and sign extension of loaded samples
   always_comb begin
      sc_half = $signed((WORD_BITS + 1)'(1) << (lg - LGW'(1)));
      sc_re   = ($signed({ram_rdata.re[WORD_BITS-1], ram_rdata.re}) + sc_half) >>> lg;
      sc_im   = ($signed({ram_rdata.im[WORD_BITS-1], ram_rdata.im}) + sc_half) >>> lg;
      scaled.re = sc_re[WORD_BITS-1:0];
      scaled.im = sc_im[WORD_BITS-1:0];
      load_word.re = {{(WORD_BITS-SAMPLE_BITS){req.sample_re[SAMPLE_BITS-1]}}, req.sample_re};
      load_word.im = {{(WORD_BITS-SAMPLE_BITS){req.sample_im[SAMPLE_BITS-1]}}, req.sample_im};
   end

   assign req_accept = req.valid && req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req.action == ACT_READ) begin
                  state_in = ST_RSP;
               end else if (trigger) begin
                  state_in = inverse_ff ? ST_BR_RD_I : ST_BF_RD_T;
               end
            end
         end
         ST_RSP:     state_in = ST_IDLE;
         ST_BF_RD_T: state_in = ST_BF_RD_U;
         ST_BF_RD_U: state_in = ST_BF_PRE;
         ST_BF_PRE:  state_in = ST_BF_MUL;
         ST_BF_MUL:  state_in = ST_BF_RND;
         ST_BF_RND:  state_in = ST_BF_WR_T;
         ST_BF_WR_T: state_in = ST_BF_WR_U;
         ST_BF_WR_U: begin
            if (k_last && stage_last) begin
               state_in = inverse_ff ? ST_SC_RD : ST_BR_RD_I;
            end else begin
               state_in = ST_BF_RD_T;
            end
         end
         ST_BR_RD_I: begin
            if (do_swap) begin
               state_in = ST_BR_RD_R;
            end else if (i_last) begin
               state_in = inverse_ff ? ST_BF_RD_T : ST_FINISH;
            end
         end
         ST_BR_RD_R: state_in = ST_BR_WR_I;
         ST_BR_WR_I: state_in = ST_BR_WR_R;
         ST_BR_WR_R: begin
            if (i_last) begin
               state_in = inverse_ff ? ST_BF_RD_T : ST_FINISH;
            end else begin
               state_in = ST_BR_RD_I;
            end
         end
         ST_SC_RD: state_in = ST_SC_WR;
         ST_SC_WR: state_in = i_last ? ST_FINISH : ST_SC_RD;
         ST_FINISH: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready    = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = load_count_ff[AW-1:0];
      ram_wdata    = load_word;
      ram_raddr    = read_count_ff[AW-1:0];
      rom_en       = 1'b0;
      bctl         = '0;
      bctl.inverse = inverse_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = !rsp_valid_ff || rsp.ready;
            ram_we    = req.valid && req_ready && (req.action == ACT_LOAD);
         end
         ST_BF_RD_T: begin
            ram_raddr = bf_t;
            rom_en    = 1'b1;
         end
         ST_BF_RD_U: begin
            ram_raddr  = bf_u;
            bctl.cap_a = 1'b1;
         end
         ST_BF_PRE: bctl.pre = 1'b1;
         ST_BF_MUL: bctl.mul = 1'b1;
         ST_BF_RND: bctl.rnd = 1'b1;
         ST_BF_WR_T: begin
            ram_we    = 1'b1;
            ram_waddr = bf_t;
            ram_wdata = res_t;
         end
         ST_BF_WR_U: begin
            ram_we    = 1'b1;
            ram_waddr = bf_u;
            ram_wdata = res_u;
         end
         ST_BR_RD_I: ram_raddr = i_ff;
         ST_BR_RD_R: begin
            ram_raddr  = br_r;
            bctl.cap_a = 1'b1;
         end
         ST_BR_WR_I: begin
            ram_we    = 1'b1;
            ram_waddr = i_ff;
            ram_wdata = ram_rdata;
         end
         ST_BR_WR_R: begin
            ram_we    = 1'b1;
            ram_waddr = br_r;
            ram_wdata = hold;
         end
         ST_SC_RD: ram_raddr = i_ff;
         ST_SC_WR: begin
            ram_we    = 1'b1;
            ram_waddr = i_ff;
            ram_wdata = scaled;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign req.ready = req_ready;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         inverse_ff     <= 1'b0;
         points_ff      <= POINTS_RESET;
         load_count_ff  <= '0;
         read_count_ff  <= '0;
         frame_ready_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               CSR_INVERSE: inverse_ff <= csr_wdata[0];
               CSR_POINTS:  points_ff  <= csr_wdata[POINTS_BITS-1:0];
               default:     inverse_ff <= inverse_ff;
            endcase
         end
         if (state_ff == ST_IDLE && req_accept) begin
            if (req.action == ACT_LOAD) begin
               frame_ready_ff <= 1'b0;
               read_count_ff  <= '0;
               load_count_ff  <= load_next;
            end else if (frame_ready_ff) begin
               if (read_count_ff >= n_last) begin
                  frame_ready_ff <= 1'b0;
                  read_count_ff  <= '0;
               end else begin
                  read_count_ff <= read_count_ff + CW'(1);
               end
            end
         end
         if (state_ff == ST_FINISH) begin
            frame_ready_ff <= 1'b1;
            load_count_ff  <= '0;
            read_count_ff  <= '0;
         end
         if (state_ff == ST_RSP) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // transform counters and result payload
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            k_ff  <= '0;
            i_ff  <= '0;
            hl_ff <= inverse_ff ? '0 : lg - LGW'(1);
            pend_status_ff <= frame_ready_ff ? STATUS_OK : STATUS_NO_FRAME;
            pend_last_ff   <= frame_ready_ff && (read_count_ff >= n_last);
            pend_index_ff  <= frame_ready_ff ? BIN_INDEX_BITS'(read_count_ff) : '0;
         end
         ST_BF_WR_U: begin
            if (k_last) begin
               k_ff <= '0;
               i_ff <= '0;
               if (!stage_last) begin
                  hl_ff <= inverse_ff ? hl_ff + LGW'(1) : hl_ff - LGW'(1);
               end
            end else begin
               k_ff <= k_ff + AW'(1);
            end
         end
         ST_BR_RD_I: begin
            if (!do_swap) begin
               i_ff <= i_ff + AW'(1);
            end
         end
         ST_BR_WR_R: i_ff <= i_ff + AW'(1);
         ST_SC_WR:   i_ff <= i_ff + AW'(1);
         ST_RSP: begin
            rsp_status_ff <= pend_status_ff;
            rsp_last_ff   <= pend_last_ff;
            rsp_index_ff  <= pend_index_ff;
            rsp_data_ff   <= (pend_status_ff == STATUS_OK) ? ram_rdata : '0;
         end
         default: begin
            k_ff <= k_ff;
         end
      endcase
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.bin_re    = rsp_data_ff.re;
   assign rsp.bin_im    = rsp_data_ff.im;
   assign rsp.bin_index = rsp_index_ff;
   assign rsp.last_bin  = rsp_last_ff;
   assign rsp.status    = rsp_status_ff;

endmodule

### hdl/cfft_work_ram.sv
// working memory of complex words, one write port and one registered read port
// depends on cfft_pkg
module cfft_work_ram import cfft_pkg::*; #(
   parameter int ADDR_BITS = 10
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  cplx_type             wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output cplx_type             rd_data
);

   cplx_type mem [2**ADDR_BITS];
   cplx_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/cfft_twiddle_rom.sv
// twiddle table of cos and sin over half a turn, registered read
// depends on cfft_pkg
module cfft_twiddle_rom import cfft_pkg::*; #(
   parameter int MAX_POINTS   = 1024,
   parameter int TWIDDLE_BITS = 16
) (
   input  logic                           clock,
   input  logic                           rd_en,
   input  logic [((($clog2(MAX_POINTS)) > 1) ? $clog2(MAX_POINTS) - 1 : 1)-1:0] rd_addr,
   output logic signed [TWIDDLE_BITS:0]   cos_out,
   output logic signed [TWIDDLE_BITS:0]   sin_out
);

   localparam int AW   = $clog2(MAX_POINTS);
   localparam int HALF = MAX_POINTS / 2;
   localparam longint unsigned PI_Q44 = 64'h3243F6A8885A;

   logic signed [TWIDDLE_BITS:0] cos_tab [HALF];
   logic signed [TWIDDLE_BITS:0] sin_tab [HALF];
   logic signed [TWIDDLE_BITS:0] cos_ff;
   logic signed [TWIDDLE_BITS:0] sin_ff;

   function automatic longint unsigned qsin(input longint unsigned j);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      x    = (((j * PI_Q44) >> (AW + 1)) + 64'd8192) >> 14;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      term = ((term * x2) >> 30) / 6;   sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 20;  sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 42;  sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 72;  sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 110; sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 156; sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 210; sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 272; sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 342; sum = sum - longint'(term);
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > (64'sd1 <<< 30)) begin
         sum = 64'sd1 <<< 30;
      end
      return (longint'(sum) + (64'd1 << (30 - TWIDDLE_BITS))) >> (31 - TWIDDLE_BITS);
   endfunction

   function automatic logic signed [TWIDDLE_BITS:0] cos_entry(input int m);
      longint unsigned p;
      p = 4 * longint'(m);
      if (p <= MAX_POINTS) begin
         return (TWIDDLE_BITS + 1)'(qsin(MAX_POINTS - p));
      end
      return -((TWIDDLE_BITS + 1)'(qsin(p - MAX_POINTS)));
   endfunction

   function automatic logic signed [TWIDDLE_BITS:0] sin_entry(input int m);
      longint unsigned p;
      p = 4 * longint'(m);
      if (p <= MAX_POINTS) begin
         return (TWIDDLE_BITS + 1)'(qsin(p));
      end
      return (TWIDDLE_BITS + 1)'(qsin(2 * MAX_POINTS - p));
   endfunction

   always_comb begin
      for (int m = 0; m < HALF; m++) begin
         cos_tab[m] = cos_entry(m);
         sin_tab[m] = sin_entry(m);
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         cos_ff <= cos_tab[rd_addr];
         sin_ff <= sin_tab[rd_addr];
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

### hdl/cfft_butterfly.sv
// butterfly: fwd pre add, complex twiddle multiply, rounding, inv post add
// depends on cfft_pkg
module cfft_butterfly import cfft_pkg::*; #(
   parameter int TWIDDLE_BITS = 16
) (
   input  logic                         clock,
   input  bfly_ctrl_type                ctrl,
   input  cplx_type                     rd_data,
   input  logic signed [TWIDDLE_BITS:0] w_cos,
   input  logic signed [TWIDDLE_BITS:0] w_sin,
   output cplx_type                     res_t,
   output cplx_type                     res_u,
   output cplx_type                     hold
);

   localparam int PW = WORD_BITS + TWIDDLE_BITS + 1;
   localparam logic signed [PW:0] RND_HALF = (PW + 1)'(1) << (TWIDDLE_BITS - 2);

   cplx_type a_ff, s_ff, x_ff, p_ff;
   logic signed [PW-1:0] prr_ff, pii_ff, pri_ff, pir_ff;
   logic signed [TWIDDLE_BITS:0] w_im;
   logic signed [PW:0] sum_re, sum_im;

   function automatic logic signed [WORD_BITS-1:0] scale_sat(input logic signed [PW:0] v);
      logic signed [PW:0] sh;
      sh = (v + RND_HALF) >>> (TWIDDLE_BITS - 1);
      if (&sh[PW:WORD_BITS-1] || ~|sh[PW:WORD_BITS-1]) begin
         return sh[WORD_BITS-1:0];
      end
      return sh[PW] ? {1'b1, {(WORD_BITS-1){1'b0}}} : {1'b0, {(WORD_BITS-1){1'b1}}};
   endfunction

   assign w_im   = ctrl.inverse ? w_sin : -w_sin;
   assign sum_re = {prr_ff[PW-1], prr_ff} - {pii_ff[PW-1], pii_ff};
   assign sum_im = {pri_ff[PW-1], pri_ff} + {pir_ff[PW-1], pir_ff};

   always_ff @(posedge clock) begin
      if (ctrl.cap_a) begin
         a_ff <= rd_data;
      end
      if (ctrl.pre) begin
         s_ff.re <= add_sat(a_ff.re, rd_data.re);
         s_ff.im <= add_sat(a_ff.im, rd_data.im);
         if (ctrl.inverse) begin
            x_ff <= rd_data;
         end else begin
            x_ff.re <= sub_sat(a_ff.re, rd_data.re);
            x_ff.im <= sub_sat(a_ff.im, rd_data.im);
         end
      end
      if (ctrl.mul) begin
         prr_ff <= x_ff.re * w_cos;
         pii_ff <= x_ff.im * w_im;
         pri_ff <= x_ff.re * w_im;
         pir_ff <= x_ff.im * w_cos;
      end
      if (ctrl.rnd) begin
         p_ff.re <= scale_sat(sum_re);
         p_ff.im <= scale_sat(sum_im);
      end
   end

   always_comb begin
      if (ctrl.inverse) begin
         res_t.re = add_sat(a_ff.re, p_ff.re);
         res_t.im = add_sat(a_ff.im, p_ff.im);
         res_u.re = sub_sat(a_ff.re, p_ff.re);
         res_u.im = sub_sat(a_ff.im, p_ff.im);
      end else begin
         res_t = s_ff;
         res_u = p_ff;
      end
   end

   assign hold = a_ff;

endmodule
